// ===== design/jsu_pkg.sv =====
// jsu_pkg: shared types and codes for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_CONTROL      = 4'd1;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd2;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
  localparam logic [3:0] ERR_BAD_PAIR     = 4'd4;
  localparam logic [3:0] ERR_MISSING_PAIR = 4'd5;
  localparam logic [3:0] ERR_CUT_ESCAPE   = 4'd6;
  localparam logic [3:0] ERR_CUT_HEX      = 4'd7;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd8;

  // depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       last;
  } out_item_t;

  // one job: a code point to encode, or a done/error marker
  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  len_m1;      // utf-8 byte count minus one
    logic [1:0]  kind;
    logic [3:0]  error_code;
  } job_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

// ===== design/jsu_front.sv =====
// jsu_front: accepts text bytes, runs the string parser and issues jobs
`timescale 1ns / 1ps

module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  jsu_pkg::in_item_t item_i,
  output logic             job_valid_o,
  output jsu_pkg::job_t    job_o
);
  import jsu_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_STR     = 4'd1;
  localparam logic [3:0] PH_ESC     = 4'd2;
  localparam logic [3:0] PH_HEX1    = 4'd3;
  localparam logic [3:0] PH_WANT_BS = 4'd4;
  localparam logic [3:0] PH_WANT_U  = 4'd5;
  localparam logic [3:0] PH_HEX2    = 4'd6;
  localparam logic [3:0] PH_ERR     = 4'd7;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;

  logic [7:0]  c;
  logic [4:0]  hex_val;
  logic [15:0] acc_new;
  logic [20:0] pair_cp;

  // hex digit value, bit 4 set when not a digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      v = {1'b0, b[3:0] + 4'd9};
    return v;
  endfunction

  function automatic job_t cp_job(input logic [20:0] cp);
    job_t j;
    j.code_point = cp;
    j.kind       = KIND_DATA;
    j.error_code = ERR_NONE;
    if (cp <= 21'h7f)        j.len_m1 = 2'd0;
    else if (cp <= 21'h7ff)  j.len_m1 = 2'd1;
    else if (cp <= 21'hffff) j.len_m1 = 2'd2;
    else                     j.len_m1 = 2'd3;
    return j;
  endfunction

  function automatic job_t mark_job(input logic [1:0] kind, input logic [3:0] err);
    job_t j;
    j.code_point = '0;
    j.len_m1     = 2'd0;
    j.kind       = kind;
    j.error_code = err;
    return j;
  endfunction

  assign c       = item_i.in_byte;
  assign hex_val = hex_digit(c);
  assign acc_new = {acc_q[11:0], hex_val[3:0]};
  assign pair_cp = 21'h10000 + {1'b0, hs_q, acc_new[9:0]};

  // next state and job
  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    hs_d        = hs_q;
    job_valid_o = 1'b0;
    job_o       = mark_job(KIND_DATA, ERR_NONE);
    if (item_i.end_of_text) begin
      case (phase_q)
        PH_STR: begin
          job_valid_o = 1'b1;
          job_o       = mark_job(KIND_ERROR, ERR_UNTERMINATED);
        end
        PH_ESC: begin
          job_valid_o = 1'b1;
          job_o       = mark_job(KIND_ERROR, ERR_CUT_ESCAPE);
        end
        PH_HEX1, PH_HEX2: begin
          job_valid_o = 1'b1;
          job_o       = mark_job(KIND_ERROR, ERR_CUT_HEX);
        end
        PH_WANT_BS, PH_WANT_U: begin
          job_valid_o = 1'b1;
          job_o       = mark_job(KIND_ERROR, ERR_MISSING_PAIR);
        end
        default: ;
      endcase
      phase_d = PH_IDLE;
      acc_d   = '0;
      cnt_d   = '0;
    end else begin
      case (phase_q)
        PH_STR: begin
          job_valid_o = 1'b1;
          if (c == 8'h22) begin
            phase_d = PH_IDLE;
            job_o   = mark_job(KIND_DONE, ERR_NONE);
          end else if (c < 8'h20) begin
            phase_d = PH_ERR;
            job_o   = mark_job(KIND_ERROR, ERR_CONTROL);
          end else if (c == 8'h5c) begin
            phase_d     = PH_ESC;
            job_valid_o = 1'b0;
          end else begin
            // text bytes go out as one byte, 0x80 and above unchanged
            job_o        = cp_job({13'd0, c});
            job_o.len_m1 = 2'd0;
          end
        end
        PH_ESC: begin
          if (c == 8'h75) begin
            phase_d = PH_HEX1;
            acc_d   = '0;
            cnt_d   = '0;
          end else begin
            job_valid_o = 1'b1;
            phase_d     = PH_STR;
            case (c)
              8'h22, 8'h5c, 8'h2f: job_o = cp_job({13'd0, c});
              8'h62:               job_o = cp_job(21'h08);
              8'h66:               job_o = cp_job(21'h0c);
              8'h6e:               job_o = cp_job(21'h0a);
              8'h72:               job_o = cp_job(21'h0d);
              8'h74:               job_o = cp_job(21'h09);
              default: begin
                phase_d = PH_ERR;
                job_o   = mark_job(KIND_ERROR, ERR_BAD_ESCAPE);
              end
            endcase
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (hex_val[4]) begin
            phase_d     = PH_ERR;
            job_valid_o = 1'b1;
            job_o       = mark_job(KIND_ERROR, ERR_BAD_HEX);
          end else begin
            acc_d = acc_new;
            if (cnt_q != 2'd3) begin
              cnt_d = cnt_q + 2'd1;
            end else begin
              cnt_d = '0;
              if (phase_q == PH_HEX1) begin
                if (acc_new >= 16'hd800 && acc_new <= 16'hdbff) begin
                  hs_d    = acc_new[9:0];
                  phase_d = PH_WANT_BS;
                end else begin
                  phase_d     = PH_STR;
                  job_valid_o = 1'b1;
                  job_o       = cp_job({5'd0, acc_new});
                end
              end else begin
                job_valid_o = 1'b1;
                if (acc_new >= 16'hdc00 && acc_new <= 16'hdfff) begin
                  phase_d = PH_STR;
                  job_o   = cp_job(pair_cp);
                end else begin
                  phase_d = PH_ERR;
                  job_o   = mark_job(KIND_ERROR, ERR_BAD_PAIR);
                end
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (c == 8'h5c) begin
            phase_d = PH_WANT_U;
          end else begin
            phase_d     = PH_ERR;
            job_valid_o = 1'b1;
            job_o       = mark_job(KIND_ERROR, ERR_MISSING_PAIR);
          end
        end
        PH_WANT_U: begin
          if (c == 8'h75) begin
            phase_d = PH_HEX2;
            acc_d   = '0;
            cnt_d   = '0;
          end else begin
            phase_d     = PH_ERR;
            job_valid_o = 1'b1;
            job_o       = mark_job(KIND_ERROR, ERR_MISSING_PAIR);
          end
        end
        default: begin
          // idle, sticky error and unused codes: wait for an opening quote
          if (c == 8'h22) begin
            phase_d = PH_STR;
            acc_d   = '0;
            cnt_d   = '0;
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      hs_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hs_q    <= hs_d;
    end
  end

endmodule

// ===== design/jsu_queue.sv =====
// jsu_queue: short job queue between parser front and encoder back
`timescale 1ns / 1ps

module jsu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsu_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output jsu_pkg::head_t head_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o        = (cnt_q == CntW'(QUEUE_DEPTH));
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.job    = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

// ===== design/jsu_back.sv =====
// jsu_back: turns jobs into utf-8 bytes and markers, one item per cycle while the output is taken
`timescale 1ns / 1ps

module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::head_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_item_o
);
  import jsu_pkg::*;

  logic      busy_q;
  job_t      job_q;
  logic [1:0] idx_q;
  logic      adv;
  logic      is_last;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  assign adv     = busy_q && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == job_q.len_m1);
  assign pop_o   = head_i.valid && (!busy_q || (adv && is_last));

  // byte of the current job at the current index
  always_comb begin
    out_d.kind       = job_q.kind;
    out_d.error_code = job_q.error_code;
    out_d.last       = is_last;
    out_d.out_byte   = 8'h00;
    if (job_q.kind == KIND_DATA) begin
      case ({job_q.len_m1, idx_q})
        // single byte: ascii code point or raw text byte
        4'b00_00: out_d.out_byte = job_q.code_point[7:0];
        4'b01_00: out_d.out_byte = {3'b110, job_q.code_point[10:6]};
        4'b10_00: out_d.out_byte = {4'b1110, job_q.code_point[15:12]};
        4'b11_00: out_d.out_byte = {5'b11110, job_q.code_point[20:18]};
        4'b11_01: out_d.out_byte = {2'b10, job_q.code_point[17:12]};
        4'b10_01, 4'b11_10: out_d.out_byte = {2'b10, job_q.code_point[11:6]};
        4'b01_01, 4'b10_10, 4'b11_11: out_d.out_byte = {2'b10, job_q.code_point[5:0]};
        default: out_d.out_byte = 8'h00;
      endcase
    end
  end

  // current job and byte index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (adv) begin
      busy_q <= !is_last;
      idx_q  <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= head_i.job;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/json_string_unescape_utf8_core.sv =====
// json_string_unescape_utf8_core: one text byte per item in, utf-8 bytes and markers out
// Throughput: one input item per cycle while the job queue has room; each result
//   item is one step of the encoder, so an escape yielding k bytes holds it for k steps.
// Path: with queue and encoder empty, the job of an accepted item is written to the queue,
//   then the encoder takes the job, then loads the output register.
// Reset: asynchronous, active low; parser returns to waiting for a quote, queue and
//   output empty. Payload registers are not reset.
`timescale 1ns / 1ps

module json_string_unescape_utf8_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jsu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_item_o
);
  import jsu_pkg::*;

  logic  accept;
  logic  job_valid;
  job_t  job;
  logic  push;
  logic  full;
  logic  pop;
  head_t head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && job_valid;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  jsu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // the encoder never takes a job from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("job popped from empty queue");

  // markers are single-item results
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KIND_DATA |-> out_item_o.last)
    else $error("marker result without last");

  // an error code appears exactly on error results
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.kind == KIND_ERROR) == (out_item_o.error_code != ERR_NONE)))
    else $error("error code does not match kind");

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while waiting");
`endif

endmodule

// ===== verif/jsu_unescape_checker.sv =====
// jsu_unescape_checker: decodes the accepted text items and compares every result item
`timescale 1ns / 1ps

module jsu_unescape_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  jsu_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  jsu_pkg::out_item_t out_item_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_count_o
);
  import jsu_pkg::*;

  // scanner position within the text
  typedef enum logic [3:0] {
    ST_IDLE           = 4'd0,
    ST_STRING         = 4'd1,
    ST_ESCAPE         = 4'd2,
    ST_HEX_FIRST      = 4'd3,
    ST_WANT_BACKSLASH = 4'd4,
    ST_WANT_U         = 4'd5,
    ST_HEX_SECOND     = 4'd6,
    ST_ERROR          = 4'd7
  } scan_state_e;

  scan_state_e scan_state;
  logic [15:0] hex_acc;
  logic [1:0]  digit_cnt;
  logic [9:0]  high_bits;
  out_item_t   decoded_q[$];
  out_item_t   oldest;
  int unsigned mismatches;

  // queue one decoded result, last flag fixed up per item
  task automatic push_result(input logic [7:0] b, input logic [1:0] k, input logic [3:0] e);
    out_item_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.error_code = e;
    r.last       = 1'b0;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic raise_error(input logic [3:0] e);
    scan_state = ST_ERROR;
    push_result(8'h00, KIND_ERROR, e);
  endtask

  // utf-8 encoding of one code point
  task automatic push_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_result(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      push_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      push_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      push_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endtask

  // one text item through the scanner
  task automatic decode_item(input in_item_t item);
    int unsigned first_idx;
    logic [7:0]  c;
    logic [8:0]  esc;
    logic [4:0]  digit;
    first_idx = decoded_q.size();
    c = item.in_byte;
    if (item.end_of_text) begin
      case (scan_state)
        ST_STRING:                    push_result(8'h00, KIND_ERROR, ERR_UNTERMINATED);
        ST_ESCAPE:                    push_result(8'h00, KIND_ERROR, ERR_CUT_ESCAPE);
        ST_HEX_FIRST, ST_HEX_SECOND:  push_result(8'h00, KIND_ERROR, ERR_CUT_HEX);
        ST_WANT_BACKSLASH, ST_WANT_U: push_result(8'h00, KIND_ERROR, ERR_MISSING_PAIR);
        default: ;
      endcase
      scan_state = ST_IDLE;
      hex_acc    = '0;
      digit_cnt  = '0;
    end else begin
      case (scan_state)
        ST_STRING: begin
          if (c == "\"") begin
            scan_state = ST_IDLE;
            push_result(8'h00, KIND_DONE, ERR_NONE);
          end else if (c < 8'h20) begin
            raise_error(ERR_CONTROL);
          end else if (c == "\\") begin
            scan_state = ST_ESCAPE;
          end else begin
            push_result(c, KIND_DATA, ERR_NONE);
          end
        end
        ST_ESCAPE: begin
          if (c == "u") begin
            scan_state = ST_HEX_FIRST;
            hex_acc    = '0;
            digit_cnt  = '0;
          end else begin
            case (c)
              "\"", "\\", "/": esc = {1'b0, c};
              "b":             esc = 9'h008;
              "f":             esc = 9'h00C;
              "n":             esc = 9'h00A;
              "r":             esc = 9'h00D;
              "t":             esc = 9'h009;
              default:         esc = 9'h100;
            endcase
            if (esc[8]) begin
              raise_error(ERR_BAD_ESCAPE);
            end else begin
              scan_state = ST_STRING;
              push_result(esc[7:0], KIND_DATA, ERR_NONE);
            end
          end
        end
        ST_HEX_FIRST, ST_HEX_SECOND: begin
          if (c >= 8'h30 && c <= 8'h39) begin
            digit = 5'(c - 8'h30);
          end else if (c >= 8'h61 && c <= 8'h66) begin
            digit = 5'(c - 8'h61 + 8'd10);
          end else if (c >= 8'h41 && c <= 8'h46) begin
            digit = 5'(c - 8'h41 + 8'd10);
          end else begin
            digit = 5'd16;
          end
          if (digit[4]) begin
            raise_error(ERR_BAD_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], digit[3:0]};
            if (digit_cnt != 2'd3) begin
              digit_cnt = digit_cnt + 2'd1;
            end else begin
              digit_cnt = '0;
              if (scan_state == ST_HEX_FIRST) begin
                // high surrogate waits for its partner
                if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                  high_bits  = hex_acc[9:0];
                  scan_state = ST_WANT_BACKSLASH;
                end else begin
                  scan_state = ST_STRING;
                  push_code_point({5'd0, hex_acc});
                end
              end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                scan_state = ST_STRING;
                push_code_point(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
              end else begin
                raise_error(ERR_BAD_PAIR);
              end
            end
          end
        end
        ST_WANT_BACKSLASH: begin
          if (c == "\\") scan_state = ST_WANT_U;
          else raise_error(ERR_MISSING_PAIR);
        end
        ST_WANT_U: begin
          if (c == "u") begin
            scan_state = ST_HEX_SECOND;
            hex_acc    = '0;
            digit_cnt  = '0;
          end else begin
            raise_error(ERR_MISSING_PAIR);
          end
        end
        // outside a string or after an error, only a quote matters
        default: begin
          if (c == "\"") begin
            scan_state = ST_STRING;
            hex_acc    = '0;
            digit_cnt  = '0;
          end
        end
      endcase
    end
    if (decoded_q.size() > first_idx) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // compare results first, then decode the new text item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_state = ST_IDLE;
      hex_acc    = '0;
      digit_cnt  = '0;
      high_bits  = '0;
      mismatches = 0;
      decoded_q.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none actual byte %0h kind %0d error %0d last %0d",
                   $time, out_item_i.out_byte, out_item_i.kind, out_item_i.error_code,
                   out_item_i.last);
        end else begin
          oldest = decoded_q.pop_front();
          compare_field("out_byte", oldest.out_byte, out_item_i.out_byte);
          compare_field("kind", 8'(oldest.kind), 8'(out_item_i.kind));
          compare_field("error_code", 8'(oldest.error_code), 8'(out_item_i.error_code));
          compare_field("last", 8'(oldest.last), 8'(out_item_i.last));
        end
      end
      if (in_valid_i && in_ready_i) decode_item(in_item_i);
      mismatch_count_o <= mismatches;
      pending_count_o  <= decoded_q.size();
    end
  end

endmodule

// ===== verif/tb_json_string_unescape_utf8_core.sv =====
// tb_json_string_unescape_utf8_core: text stimulus, stalls and verdict for the unescaper
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_core;
  import jsu_pkg::*;

  localparam int unsigned STALL_PCT   = 19;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TOTAL_ITEMS = 280;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        calm      = 1'b0;
  int unsigned mismatch_total;
  int unsigned pending_results;
  int unsigned idle_cycles = 0;
  int unsigned text_items  = 0;

  always #2 clk = ~clk;

  json_string_unescape_utf8_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  jsu_unescape_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatch_total),
    .pending_count_o  (pending_results)
  );

  // receiver stalls at random outside the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic offer_item(input logic [7:0] b, input logic eot);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_byte: b, end_of_text: eot};
    text_items++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_byte(input logic [7:0] b);
    offer_item(b, 1'b0);
  endtask

  task automatic offer_end();
    offer_item(8'($urandom), 1'b1);
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_byte(s[i]);
  endtask

  // \u escape with hex letters in random case
  task automatic offer_u_escape(input logic [15:0] v);
    logic [3:0] nib;
    offer_text("\\u");
    for (int i = 3; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) offer_byte(8'h30 + 8'(nib));
      else offer_byte(($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10);
    end
  endtask

  // one broken construct inside a string
  task automatic offer_fault();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(5))
      0: offer_byte(8'($urandom_range(0, 31)));
      1: begin
        c = 8'($urandom);
        if (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"}) c = "q";
        offer_byte("\\");
        offer_byte(c);
      end
      2: begin
        offer_text("\\u");
        repeat ($urandom_range(0, 3)) offer_byte("7");
        c = 8'($urandom);
        if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) c = "g";
        offer_byte(c);
      end
      3: begin
        offer_u_escape(16'hD800 | 16'(10'($urandom)));
        v = 16'($urandom);
        if (v[15:10] == 6'b110111) v[15] = 1'b0;
        offer_u_escape(v);
      end
      4: begin
        offer_u_escape(16'hD800 | 16'(10'($urandom)));
        c = 8'($urandom);
        if ($urandom_range(1)) begin
          if (c == "\\") c = "x";
          offer_byte(c);
        end else begin
          if (c == "u") c = "U";
          offer_byte("\\");
          offer_byte(c);
        end
      end
      default: begin
        offer_byte("\\");
        if ($urandom_range(1)) begin
          offer_byte("u");
          repeat ($urandom_range(0, 3)) offer_byte("c");
        end
        offer_end();
      end
    endcase
  endtask

  // mostly well-formed string with random content
  task automatic offer_random_string();
    int unsigned pick;
    logic [7:0]  c;
    logic [15:0] v;
    offer_byte("\"");
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        c = 8'($urandom_range(8'h20, 8'hFF));
        if (c == "\"" || c == "\\") c = "~";
        offer_byte(c);
      end else if (pick < 55) begin
        case ($urandom_range(7))
          0:       c = "\"";
          1:       c = "\\";
          2:       c = "/";
          3:       c = "b";
          4:       c = "f";
          5:       c = "n";
          6:       c = "r";
          default: c = "t";
        endcase
        offer_byte("\\");
        offer_byte(c);
      end else if (pick < 80) begin
        case ($urandom_range(4))
          0:       v = 16'($urandom_range(16'h0000, 16'h007F));
          1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
          2:       v = 16'($urandom_range(16'h0800, 16'hD7FF));
          3:       v = 16'($urandom_range(16'hE000, 16'hFFFF));
          default: v = 16'($urandom_range(16'hDC00, 16'hDFFF));
        endcase
        offer_u_escape(v);
      end else if (pick < 94) begin
        offer_u_escape(16'hD800 | 16'(10'($urandom)));
        offer_u_escape(16'hDC00 | 16'(10'($urandom)));
      end else begin
        offer_fault();
      end
    end
    if ($urandom_range(99) < 85) offer_byte("\"");
    else offer_end();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain bytes at the range limits, then bytes outside a string
    offer_byte("\"");
    offer_text(" A~");
    offer_byte(8'h7F);
    offer_byte(8'h80);
    offer_byte(8'hFF);
    offer_byte("\"");
    offer_text("xy\\u");
    offer_end();
    // all simple escapes
    offer_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    // no idling on either side through the unicode escape checks
    calm <= 1'b1;
    // unicode escapes at each utf-8 length boundary up to three bytes
    offer_text("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uaBcD\"");
    // surrogate pairs and lone low surrogates
    offer_text("\"\\uD83D\\uDE00\\uDBFF\\uDFFF\\uD800\\uDC00\\uDC00\\uDFFF\"");
    calm <= 1'b0;
    // control bytes, sticky error until the next quote
    offer_text("\"a");
    offer_byte(8'h1F);
    offer_text("b\"");
    offer_byte(8'h00);
    offer_byte("\"");
    // bad escape, then an unterminated string
    offer_text("\"\\x\"");
    offer_end();
    // bad hex digit
    offer_text("\"\\u12g4\"\"");
    // low half out of range
    offer_text("\"\\uD800\\u0041\"\"");
    // missing second half
    offer_text("\"\\uD800x\"\\uD800\\n\"");
    // end of text at each point of an escape
    offer_text("\"\\");
    offer_end();
    offer_text("\"\\u12");
    offer_end();
    offer_text("\"\\uD800");
    offer_end();
    offer_text("\"\\uD800\\");
    offer_end();
    offer_text("\"\\uD800\\u1");
    offer_end();
    offer_text("\"\\q");
    offer_end();

    // random strings with some noise between them
    while (text_items < TOTAL_ITEMS) begin
      offer_random_string();
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(4) == 0) offer_end();
          else offer_byte(8'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then let stray results show up
    do @(posedge clk); while (pending_results != 0);
    repeat (12) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
